// ===== hdl/page_boundary_write_splitter_assert.svh =====
// ----------------------------------------------------------------------------
// page_boundary_write_splitter_assert.svh
// Assertion macros shared by the write splitter modules.
// Each macro expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef PAGE_BOUNDARY_WRITE_SPLITTER_ASSERT_SVH
`define PAGE_BOUNDARY_WRITE_SPLITTER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define PBWS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define PBWS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/pbws_pkg.sv =====
// ----------------------------------------------------------------------------
// pbws_pkg
// Types, codes and sizes shared by the page boundary write splitter.
// ----------------------------------------------------------------------------
package pbws_pkg;

  // field widths
  localparam int OFF_W  = 24;
  localparam int LEN_W  = 16;
  localparam int PC_W   = 13;
  localparam int PS_W   = 5;
  localparam int BS_W   = 11;
  localparam int ERR_W  = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // longest run of chunks for one request
  localparam int MAX_CHUNKS = 64;
  localparam int LIM_W      = $clog2(MAX_CHUNKS + 1) + BS_W;

  // end address width (offset plus length)
  localparam int END_W = OFF_W + 1;

  // command queue depth
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // error codes
  localparam logic [ERR_W-1:0] ERR_NONE       = 2'd0;
  localparam logic [ERR_W-1:0] ERR_ZERO_LEN   = 2'd1;
  localparam logic [ERR_W-1:0] ERR_BEYOND_END = 2'd2;
  localparam logic [ERR_W-1:0] ERR_TOO_MANY   = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SHIFT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE = 2'd2;

  // register reset values
  localparam logic [PC_W-1:0] PAGE_COUNT_RST = 13'd1;
  localparam logic [PS_W-1:0] PAGE_SHIFT_RST = 5'd6;
  localparam logic [BS_W-1:0] BLOCK_SIZE_RST = 11'd32;

  typedef struct packed {
    logic [PC_W-1:0] page_count;
    logic [PS_W-1:0] page_shift;
    logic [BS_W-1:0] block_size;
  } pbws_cfg_t;

  // classified request as it waits in the queue
  typedef struct packed {
    logic [OFF_W-1:0] off;
    logic [LEN_W-1:0] len;
    logic [ERR_W-1:0] err;
  } pbws_cmd_t;

  // block size with zero read as one
  function automatic logic [BS_W-1:0] eff_block_size(input logic [BS_W-1:0] bs);
    logic [BS_W-1:0] res;
    res = (bs == '0) ? BS_W'(1) : bs;
    return res;
  endfunction

endpackage

// ===== hdl/pbws_if.sv =====
// ----------------------------------------------------------------------------
// pbws_req_if / pbws_chunk_if
// Valid/ready channels for write requests and chunk commands.
// ----------------------------------------------------------------------------
interface pbws_req_if;
  logic                       valid;
  logic                       ready;
  logic [pbws_pkg::OFF_W-1:0] start_offset;
  logic [pbws_pkg::LEN_W-1:0] byte_count;

  modport source (output valid, output start_offset, output byte_count, input ready);
  modport sink   (input valid, input start_offset, input byte_count, output ready);
endinterface

interface pbws_chunk_if;
  logic                       valid;
  logic                       ready;
  logic [pbws_pkg::OFF_W-1:0] chunk_offset;
  logic [pbws_pkg::LEN_W-1:0] chunk_length;
  logic                       last_chunk;
  logic [pbws_pkg::ERR_W-1:0] error_code;

  modport source (output valid, output chunk_offset, output chunk_length,
                  output last_chunk, output error_code, input ready);
  modport sink   (input valid, input chunk_offset, input chunk_length,
                  input last_chunk, input error_code, output ready);
endinterface

// ===== hdl/pbws_front.sv =====
// ----------------------------------------------------------------------------
// pbws_front
// Accepts write requests and classifies them: error code or a run to split.
// ----------------------------------------------------------------------------
module pbws_front (
  pbws_req_if.sink                in_req,
  input  pbws_pkg::pbws_cfg_t     cfg,
  input  logic                    q_full,
  output logic                    push,
  output pbws_pkg::pbws_cmd_t     push_cmd
);
  import pbws_pkg::*;

  logic [END_W-1:0] last_byte;
  logic [END_W-1:0] hi_page;
  logic [END_W-1:0] lo_page;
  logic [END_W-1:0] span;
  logic [LIM_W-1:0] blk_limit;
  logic             paged;
  logic             beyond;
  logic             too_many;

  // request taken whenever the queue has room
  assign in_req.ready = !q_full;
  assign push         = in_req.valid && !q_full;

  // page index of the first and the last byte
  assign last_byte = {1'b0, in_req.start_offset} + END_W'(in_req.byte_count) - END_W'(1);
  assign hi_page   = last_byte >> cfg.page_shift;
  assign lo_page   = {1'b0, in_req.start_offset} >> cfg.page_shift;
  assign span      = hi_page - lo_page;

  // last byte at or past page_count pages is outside the device
  assign beyond = hi_page >= END_W'(cfg.page_count);

  // run length check for both modes
  assign paged     = cfg.page_count != PC_W'(1);
  assign blk_limit = LIM_W'(MAX_CHUNKS) * LIM_W'(eff_block_size(cfg.block_size));
  assign too_many  = paged ? (span >= END_W'(MAX_CHUNKS))
                           : (LIM_W'(in_req.byte_count) > blk_limit);

  // classification in check order
  always_comb begin
    push_cmd.off = in_req.start_offset;
    push_cmd.len = in_req.byte_count;
    priority if (in_req.byte_count == '0) begin
      push_cmd.err = ERR_ZERO_LEN;
    end else if (beyond) begin
      push_cmd.err = ERR_BEYOND_END;
    end else if (too_many) begin
      push_cmd.err = ERR_TOO_MANY;
    end else begin
      push_cmd.err = ERR_NONE;
    end
  end

endmodule

// ===== hdl/pbws_queue.sv =====
// ----------------------------------------------------------------------------
// pbws_queue
// Short command queue between the classifier and the chunk sequencer.
// ----------------------------------------------------------------------------
`include "page_boundary_write_splitter_assert.svh"

module pbws_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  pbws_pkg::pbws_cmd_t push_cmd,
  output logic                full,
  input  logic                pop,
  output pbws_pkg::pbws_cmd_t pop_cmd,
  output logic                not_empty
);
  import pbws_pkg::*;

  pbws_cmd_t         mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign full      = count_r == QCNT_W'(QDEPTH);
  assign not_empty = count_r != '0;
  assign pop_cmd   = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  // checks
  `PBWS_ASSERT_IMP(a_q_no_overflow, push, !full || pop, "queue written while full")
  `PBWS_ASSERT_IMP(a_q_no_underflow, pop, not_empty, "queue read while empty")

endmodule

// ===== hdl/pbws_back.sv =====
// ----------------------------------------------------------------------------
// pbws_back
// Chunk sequencer: walks one command and issues one chunk per cycle while the output is taken.
// ----------------------------------------------------------------------------
`include "page_boundary_write_splitter_assert.svh"

module pbws_back (
  input  logic                clk,
  input  logic                rst_n,
  input  pbws_pkg::pbws_cfg_t cfg,
  input  logic                q_not_empty,
  input  pbws_pkg::pbws_cmd_t q_cmd,
  output logic                pop,
  pbws_chunk_if.source        out_chunk
);
  import pbws_pkg::*;

  logic             busy_r, busy_nxt;
  logic [OFF_W-1:0] off_r, off_nxt;
  logic [LEN_W-1:0] rem_r, rem_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [OFF_W-1:0] out_off_r, out_off_nxt;
  logic [LEN_W-1:0] out_len_r, out_len_nxt;
  logic             out_last_r, out_last_nxt;
  logic [ERR_W-1:0] out_err_r, out_err_nxt;

  logic             out_free;
  logic             step;
  logic             step_last;
  logic             paged;
  logic             ps_big;
  logic [END_W-1:0] page_size;
  logic [END_W-1:0] page_mask;
  logic [END_W-1:0] room;
  logic [BS_W-1:0]  bs_eff;
  logic [LEN_W-1:0] piece;

  // output register frees when empty or taken
  assign out_free = !out_valid_r || out_chunk.ready;
  assign pop      = !busy_r && q_not_empty && out_free;
  assign step     = busy_r && out_free;

  // room left in the current page
  assign paged     = cfg.page_count != PC_W'(1);
  assign ps_big    = cfg.page_shift > PS_W'(OFF_W);
  assign page_size = END_W'(1) << cfg.page_shift;
  assign page_mask = page_size - END_W'(1);
  assign room      = page_size - ({1'b0, off_r} & page_mask);
  assign bs_eff    = eff_block_size(cfg.block_size);

  // chunk length for this step
  always_comb begin
    if (paged) begin
      if (ps_big || (room > END_W'(rem_r))) begin
        piece = rem_r;
      end else begin
        piece = room[LEN_W-1:0];
      end
    end else begin
      piece = (rem_r < LEN_W'(bs_eff)) ? rem_r : LEN_W'(bs_eff);
    end
  end

  assign step_last = rem_r == piece;

  // sequencer and output register next values
  always_comb begin
    busy_nxt      = busy_r;
    off_nxt       = off_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r && !out_chunk.ready;
    out_off_nxt   = out_off_r;
    out_len_nxt   = out_len_r;
    out_last_nxt  = out_last_r;
    out_err_nxt   = out_err_r;
    if (pop) begin
      if (q_cmd.err != ERR_NONE) begin
        // rejected request: single error result
        out_valid_nxt = 1'b1;
        out_off_nxt   = q_cmd.off;
        out_len_nxt   = '0;
        out_last_nxt  = 1'b1;
        out_err_nxt   = q_cmd.err;
      end else begin
        busy_nxt = 1'b1;
        off_nxt  = q_cmd.off;
        rem_nxt  = q_cmd.len;
      end
    end else if (step) begin
      out_valid_nxt = 1'b1;
      out_off_nxt   = off_r;
      out_len_nxt   = piece;
      out_last_nxt  = step_last;
      out_err_nxt   = ERR_NONE;
      off_nxt       = off_r + OFF_W'(piece);
      rem_nxt       = rem_r - piece;
      busy_nxt      = !step_last;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    off_r      <= off_nxt;
    rem_r      <= rem_nxt;
    out_off_r  <= out_off_nxt;
    out_len_r  <= out_len_nxt;
    out_last_r <= out_last_nxt;
    out_err_r  <= out_err_nxt;
  end

  assign out_chunk.valid        = out_valid_r;
  assign out_chunk.chunk_offset = out_off_r;
  assign out_chunk.chunk_length = out_len_r;
  assign out_chunk.last_chunk   = out_last_r;
  assign out_chunk.error_code   = out_err_r;

  // checks
  `PBWS_ASSERT_IMP(a_err_single, out_valid_r && (out_err_r != ERR_NONE), out_last_r && (out_len_r == '0), "error result not a lone zero-length last")
  `PBWS_ASSERT_IMP(a_ok_nonzero, out_valid_r && (out_err_r == ERR_NONE), out_len_r != '0, "chunk of zero length")
  `PBWS_ASSERT_NXT(a_run_advances, step && !step_last, busy_r && (off_r == $past(off_r + OFF_W'(piece))), "run did not advance by the chunk length")

endmodule

// ===== hdl/page_boundary_write_splitter.sv =====
// ----------------------------------------------------------------------------
// page_boundary_write_splitter
// Splits a write request into page or block sized chunk commands.
// ----------------------------------------------------------------------------
// A request is accepted whenever the two-entry command queue has room. The
// chunk sequencer first loads a command and then issues one chunk per cycle
// while the output is taken, so a request gives at most MAX_CHUNKS chunks;
// a rejected request gives one error result. The single chunk sequencer
// handles one command at a time. The user must write registers only while
// no request is in flight; the block itself does not enforce it.
module page_boundary_write_splitter (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [pbws_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pbws_pkg::CFG_DATA_W-1:0]      cfg_data,
  pbws_req_if.sink                             in_req,
  pbws_chunk_if.source                         out_chunk
);
  import pbws_pkg::*;

  pbws_cfg_t cfg_r, cfg_nxt;
  logic      push;
  pbws_cmd_t push_cmd;
  logic      q_full;
  logic      pop;
  pbws_cmd_t q_cmd;
  logic      q_not_empty;

  // register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_PAGE_COUNT: cfg_nxt.page_count = cfg_data[PC_W-1:0];
        CFG_PAGE_SHIFT: cfg_nxt.page_shift = cfg_data[PS_W-1:0];
        CFG_BLOCK_SIZE: cfg_nxt.block_size = cfg_data[BS_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.page_count <= PAGE_COUNT_RST;
      cfg_r.page_shift <= PAGE_SHIFT_RST;
      cfg_r.block_size <= BLOCK_SIZE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // classifier
  pbws_front u_front (
    .in_req   (in_req),
    .cfg      (cfg_r),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // command queue
  pbws_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (pop),
    .pop_cmd   (q_cmd),
    .not_empty (q_not_empty)
  );

  // chunk sequencer
  pbws_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .q_not_empty (q_not_empty),
    .q_cmd       (q_cmd),
    .pop         (pop),
    .out_chunk   (out_chunk)
  );

endmodule

// ===== test/tb_page_boundary_write_splitter.sv =====
// ----------------------------------------------------------------------------
// tb_page_boundary_write_splitter
// Drives write requests through the splitter and checks every chunk command
// against an in-bench model of the page and block cutting rules. Covers the
// reset setup, block and paged modes at their register extremes, all three
// error codes, a long output stall that backs up the input, and random
// traffic under several sender and receiver idling mixes.
// ----------------------------------------------------------------------------
module tb_page_boundary_write_splitter;
  import pbws_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int RANDOM_ROUNDS = 8;
  localparam int ROUND_REQUESTS = 52;

  typedef struct packed {
    logic [OFF_W-1:0] off;
    logic [LEN_W-1:0] len;
    logic             last;
    logic [ERR_W-1:0] err;
  } chunk_exp_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pbws_req_if   req_if ();
  pbws_chunk_if chunk_if ();

  page_boundary_write_splitter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_req    (req_if),
    .out_chunk (chunk_if)
  );

  // register shadows used for prediction
  logic [PC_W-1:0] page_cnt_q   = PAGE_COUNT_RST;
  logic [PS_W-1:0] page_shift_q = PAGE_SHIFT_RST;
  logic [BS_W-1:0] blk_size_q   = BLOCK_SIZE_RST;

  chunk_exp_t expected_chunks[$];
  int mismatch_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int stall_hold = 0;

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("** page_boundary_write_splitter: FAILED **");
      $finish;
    end
  end

  // cut one request into the chunk commands it should produce
  function automatic void predict_chunks(input logic [OFF_W-1:0] start,
                                         input logic [LEN_W-1:0] count);
    longint unsigned off, left, dev, bs, psize, pieces, piece;
    logic [ERR_W-1:0] code;
    logic paged;
    off = start;
    left = count;
    dev = 64'(page_cnt_q) << page_shift_q;
    bs = (blk_size_q == '0) ? 64'd1 : 64'(blk_size_q);
    psize = 64'd1 << page_shift_q;
    paged = (page_cnt_q != 1);
    code = ERR_NONE;
    if (left == 0) begin
      code = ERR_ZERO_LEN;
    end else if (off + left > dev) begin
      code = ERR_BEYOND_END;
    end else begin
      if (paged)
        pieces = ((off + left - 1) >> page_shift_q) - (off >> page_shift_q) + 1;
      else
        pieces = (left + bs - 1) / bs;
      if (pieces > MAX_CHUNKS) code = ERR_TOO_MANY;
    end
    if (code != ERR_NONE) begin
      expected_chunks.push_back('{start, '0, 1'b1, code});
      return;
    end
    // page mode stops at each boundary, block mode at each block
    while (left > 0) begin
      piece = paged ? psize - (off & (psize - 1)) : bs;
      if (piece > left) piece = left;
      expected_chunks.push_back('{OFF_W'(off), LEN_W'(piece), piece == left, ERR_NONE});
      off += piece;
      left -= piece;
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    $display("mismatch %s: got 0x%0h expected 0x%0h at %0t", what, got, want, $time);
  endtask

  task automatic check_chunk();
    chunk_exp_t want;
    if (expected_chunks.size() == 0) begin
      report_mismatch("chunk with no request pending, offset", chunk_if.chunk_offset, '0);
      return;
    end
    want = expected_chunks.pop_front();
    if (chunk_if.chunk_offset !== want.off)
      report_mismatch("chunk_offset", chunk_if.chunk_offset, want.off);
    if (chunk_if.chunk_length !== want.len)
      report_mismatch("chunk_length", chunk_if.chunk_length, want.len);
    if (chunk_if.last_chunk !== want.last)
      report_mismatch("last_chunk", chunk_if.last_chunk, want.last);
    if (chunk_if.error_code !== want.err)
      report_mismatch("error_code", chunk_if.error_code, want.err);
  endtask

  // predict on each accepted request, then check each accepted chunk
  always @(posedge clk) begin
    if (rst_n) begin
      if (req_if.valid && req_if.ready)
        predict_chunks(req_if.start_offset, req_if.byte_count);
      if (chunk_if.valid && chunk_if.ready)
        check_chunk();
    end
  end

  // receiver: long hold-off first, otherwise random stalls
  always @(negedge clk) begin
    if (stall_hold > 0) begin
      chunk_if.ready <= 1'b0;
      stall_hold <= stall_hold - 1;
    end else begin
      chunk_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // offer one request, with random idle cycles ahead of it
  task automatic send_request(input logic [OFF_W-1:0] off, input logic [LEN_W-1:0] len);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.start_offset <= off;
    req_if.byte_count <= len;
    do @(posedge clk); while (!req_if.ready);
  endtask

  // stop offering and wait for every outstanding chunk
  task automatic wait_until_idle();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (expected_chunks.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [PC_W-1:0] pc, input logic [PS_W-1:0] ps,
                            input logic [BS_W-1:0] bs);
    write_reg(CFG_PAGE_COUNT, CFG_DATA_W'(pc));
    write_reg(CFG_PAGE_SHIFT, CFG_DATA_W'(ps));
    write_reg(CFG_BLOCK_SIZE, CFG_DATA_W'(bs));
    page_cnt_q = pc;
    page_shift_q = ps;
    blk_size_q = bs;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // reset setup: block mode over a 64 byte device
  task automatic test_reset_config();
    send_request(24'd0, 16'd0);
    send_request(24'd0, 16'd64);
    send_request(24'd1, 16'd63);
    send_request(24'd63, 16'd1);
    send_request(24'd0, 16'd65);
    send_request(24'hFFFFFF, 16'hFFFF);
    wait_until_idle();
  endtask

  // block size zero and maximum, offsets wrapping past 24 bits
  task automatic test_block_mode();
    set_config(13'd1, 5'd31, 11'd0);
    send_request(24'd0, 16'd64);
    send_request(24'd5, 16'd65);
    send_request(24'hFFFFF0, 16'd32);
    wait_until_idle();
    set_config(13'd1, 5'd31, 11'd2047);
    send_request(24'hFFFFFF, 16'hFFFF);
    send_request(24'd0, 16'd2047);
    wait_until_idle();
  endtask

  // page boundaries, empty device, tiny and huge pages
  task automatic test_paged_mode();
    set_config(13'd2, 5'd6, 11'd32);
    send_request(24'd0, 16'd128);
    send_request(24'd60, 16'd10);
    send_request(24'd127, 16'd1);
    send_request(24'd10, 16'd5);
    send_request(24'd64, 16'd65);
    wait_until_idle();
    set_config(13'd0, 5'd6, 11'd32);
    send_request(24'd0, 16'd1);
    send_request(24'd0, 16'd0);
    wait_until_idle();
    set_config(13'd8191, 5'd0, 11'd1);
    send_request(24'd100, 16'd64);
    send_request(24'd100, 16'd65);
    send_request(24'd8190, 16'd1);
    send_request(24'd8190, 16'd2);
    wait_until_idle();
    set_config(13'd8191, 5'd31, 11'd2047);
    send_request(24'hFFFFFF, 16'hFFFF);
    wait_until_idle();
    set_config(13'd4096, 5'd20, 11'd1024);
    send_request(24'h0FFFF0, 16'd32);
    wait_until_idle();
  endtask

  // output held off while requests keep coming, so the input stalls
  task automatic test_input_stall();
    set_config(13'd16, 5'd4, 11'd32);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    @(posedge clk);
    stall_hold = 300;
    repeat (12) send_request(OFF_W'($urandom_range(200)), LEN_W'($urandom_range(56, 1)));
    wait_until_idle();
  endtask

  // bursts separated by a full drain of the output
  task automatic test_sender_pause();
    set_config(13'd1, 5'd12, 11'd5);
    send_idle_pct = 0;
    recv_stall_pct = 58;
    repeat (2) begin
      repeat (6) send_request(OFF_W'($urandom_range(3000)), LEN_W'($urandom_range(300, 1)));
      wait_until_idle();
    end
  endtask

  // random setup, then mostly in-range requests with some raw noise
  task automatic test_random_traffic(input int send_pct, input int recv_pct, input int count);
    logic [PC_W-1:0] pc;
    logic [PS_W-1:0] ps;
    logic [BS_W-1:0] bs;
    longint unsigned dev, unit, len_max, off_max;
    logic [OFF_W-1:0] off;
    logic [LEN_W-1:0] len;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    if ($urandom_range(1)) begin
      case ($urandom_range(9))
        0: pc = '0;
        1: pc = '1;
        2, 3, 4, 5: pc = PC_W'($urandom_range(64, 2));
        default: pc = PC_W'($urandom_range(8191, 65));
      endcase
      ps = ($urandom_range(4) == 0) ? PS_W'($urandom_range(31)) : PS_W'($urandom_range(10));
      bs = BS_W'($urandom_range(2047));
    end else begin
      pc = 13'd1;
      ps = PS_W'($urandom_range(31, 8));
      bs = ($urandom_range(3) == 0) ? BS_W'($urandom_range(2047)) : BS_W'($urandom_range(64));
    end
    set_config(pc, ps, bs);
    dev = 64'(pc) << ps;
    unit = (pc != 1) ? (64'd1 << ps) : ((bs == '0) ? 64'd1 : 64'(bs));
    repeat (count) begin
      if (dev != 0 && $urandom_range(99) < 80) begin
        len_max = unit * $urandom_range(64, 1);
        if (len_max > 64'hFFFF) len_max = 64'hFFFF;
        if (len_max > dev) len_max = dev;
        len = LEN_W'($urandom_range(32'(len_max), 1));
        off_max = dev - len;
        if (off_max > 64'hFFFFFF) off_max = 64'hFFFFFF;
        off = OFF_W'($urandom_range(32'(off_max), 0));
      end else begin
        off = OFF_W'($urandom);
        len = ($urandom_range(9) == 0) ? '0 : LEN_W'($urandom);
      end
      send_request(off, len);
    end
    wait_until_idle();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req_if.valid = 1'b0;
    req_if.start_offset = '0;
    req_if.byte_count = '0;
    chunk_if.ready = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_config();
    test_block_mode();
    test_paged_mode();
    test_input_stall();
    test_sender_pause();
    for (int round = 0; round < RANDOM_ROUNDS; round++) begin
      case (round % 4)
        0: test_random_traffic(0, 0, ROUND_REQUESTS);
        1: test_random_traffic(58, 0, ROUND_REQUESTS);
        2: test_random_traffic(0, 58, ROUND_REQUESTS);
        default: test_random_traffic(20, 20, ROUND_REQUESTS);
      endcase
    end

    if (mismatch_count == 0)
      $display("** page_boundary_write_splitter: PASSED **");
    else
      $display("** page_boundary_write_splitter: FAILED **");
    $finish;
  end

endmodule
